// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the packet store RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== rtl/core/dtps_pkg.sv =====
//------------------------------------------------------------------------------
// dtps_pkg
// Shared types and constants of the packet store.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package dtps_pkg;
  localparam int DefNumEntries = 32;
  localparam int CntW = 6;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SWEEP  = 2'd1,
    CMD_COUNT  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_STORED  = 3'd0,
    KIND_DUP     = 3'd1,
    KIND_FULL    = 3'd2,
    KIND_SEND    = 3'd3,
    KIND_EXPIRED = 3'd4,
    KIND_COUNTS  = 3'd5
  } kind_t;

  localparam logic [0:0] REG_DATA_CODE = 1'b0;
  localparam logic [0:0] REG_ACK_CODE  = 1'b1;

  // One classified command handed from the front end to the engine.
  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  handle;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [31:0] seq_number;
    logic [7:0]  pkt_type;
    logic [15:0] ttl_in;
    logic [31:0] now;
  } job_t;

  // One result item.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_handle;
    logic [15:0] ttl_left;
    logic [5:0]  data_count;
    logic [5:0]  ack_count;
    logic        last;
  } res_t;
endpackage

// ===== rtl/core/dtps_front.sv =====
//------------------------------------------------------------------------------
// dtps_front
// Accepts input transfers, drops unknown commands, and queues jobs.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dtps_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  dtps_pkg::job_t in_job,
  output logic           job_valid,
  input  logic           job_take,
  output dtps_pkg::job_t job
);
  import dtps_pkg::*;

  // Two-entry queue between the front end and the engine.
  job_t        q [2];
  logic [1:0]  fill;
  logic        rd_ptr;
  logic        wr_ptr;
  logic        acc;
  logic        push;

  assign in_stall  = (fill == 2'd2);
  assign acc       = in_valid && !in_stall;
  // Unknown commands are accepted and discarded here.
  assign push      = acc && (in_job.cmd == CMD_INSERT || in_job.cmd == CMD_SWEEP ||
                             in_job.cmd == CMD_COUNT);
  assign job_valid = (fill != 2'd0);
  assign job       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (job_take) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, job_take};
    end
  end

  `ASSERT_NEVER(a_take_empty, clk, rst, job_take && fill == 2'd0)
  `ASSERT_NEVER(a_fill_range, clk, rst, fill == 2'd3)
  `ASSERT_IMPL(a_fill_full, clk, rst, (push && !job_take && fill == 2'd1) |=> in_stall)
endmodule

// ===== rtl/core/dtps_engine.sv =====
//------------------------------------------------------------------------------
// dtps_engine
// Walks the descriptor table one entry per cycle, unless a stalled result output holds a sweep, to carry out jobs.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dtps_engine #(
  parameter int NumEntries = dtps_pkg::DefNumEntries
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_take,
  input  dtps_pkg::job_t job,
  input  logic [7:0]     data_code,
  input  logic [7:0]     ack_code,
  output logic           res_valid,
  input  logic           res_stall,
  output dtps_pkg::res_t res
);
  import dtps_pkg::*;

  localparam int IdxW = $clog2(NumEntries);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_EMIT  = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  // Descriptor table, one word per entry.
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] seq;
    logic [7:0]  typ;
    logic [15:0] ttl;
    logic [31:0] stamp;
    logic [7:0]  handle;
  } ent_t;

  ent_t         mem [NumEntries];
  ent_t         rd;
  ent_t         wr_data;
  logic         wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [IdxW-1:0] rd_addr;

  state_t       state;
  state_t       state_next;
  job_t         cur;
  logic [CntW-1:0] count;
  logic [CntW-1:0] idx;
  logic [CntW-1:0] widx;
  logic [CntW-1:0] dcnt;
  logic [CntW-1:0] acnt;
  logic         rd_ok;
  logic         rd_ok_next;
  logic         res_load;
  logic         dup;
  logic         dup_hold;
  logic [31:0]  elapsed;
  logic         live;
  logic [31:0]  left;
  logic         walk_end;
  logic         res_free;

  assign res_free = !res_valid || !res_stall;

  // Registered table read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd <= mem[rd_addr];
  end

  assign elapsed  = cur.now - rd.stamp;
  assign live     = elapsed < {16'd0, rd.ttl};
  assign left     = {16'd0, rd.ttl} - elapsed;
  assign dup      = rd.src == cur.source_addr && rd.dst == cur.dest_addr &&
                    rd.seq == cur.seq_number && rd.typ == cur.pkt_type;
  assign walk_end = (idx + 1'b1 == count);

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = widx[IdxW-1:0];
    wr_data  = rd;
    rd_addr  = idx[IdxW-1:0];
    job_take = 1'b0;
    rd_ok_next = 1'b0;
    res_load = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        rd_addr = '0;
        if (job_valid) begin
          job_take = 1'b1;
          rd_ok_next = 1'b1;
          // A sweep of an empty table has no results.
          if (count != '0) state_next = S_WALK;
          else if (job.cmd == CMD_SWEEP) state_next = S_IDLE;
          else state_next = S_EMIT;
        end
      end
      S_WALK: begin
        if (rd_ok) begin
          if (cur.cmd == CMD_SWEEP) begin
            rd_ok_next = 1'b1;
            if (res_free) begin
              res_load = 1'b1;
              wr_en = live;
              wr_data.ttl = left[15:0];
              wr_data.stamp = cur.now;
              rd_addr = idx[IdxW-1:0] + 1'b1;
              if (walk_end) state_next = S_IDLE;
            end
          end else if (cur.cmd == CMD_INSERT && dup) begin
            state_next = S_EMIT;
          end else begin
            rd_ok_next = !walk_end;
            rd_addr = idx[IdxW-1:0] + 1'b1;
            if (walk_end) state_next = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (res_free) begin
          res_load = 1'b1;
          if (cur.cmd == CMD_INSERT && !dup_hold && count < CntW'(NumEntries)) begin
            state_next = S_WRITE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = count[IdxW-1:0];
        wr_data = '{cur.source_addr, cur.dest_addr, cur.seq_number, cur.pkt_type,
                    cur.ttl_in, cur.now, cur.handle};
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
      idx       <= '0;
      widx      <= '0;
      rd_ok     <= 1'b0;
      dcnt      <= '0;
      acnt      <= '0;
      dup_hold  <= 1'b0;
    end else begin
      state <= state_next;
      rd_ok <= rd_ok_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          dup_hold <= 1'b0;
          if (job_valid) begin
            cur   <= job;
            idx   <= '0;
            widx  <= '0;
            dcnt  <= '0;
            acnt  <= '0;
          end
        end
        S_WALK: begin
          if (rd_ok) begin
            if (cur.cmd == CMD_SWEEP) begin
              if (res_free) begin
                res.kind       <= live ? KIND_SEND : KIND_EXPIRED;
                res.out_handle <= rd.handle;
                res.ttl_left   <= live ? left[15:0] : 16'd0;
                res.data_count <= '0;
                res.ack_count  <= '0;
                res.last       <= walk_end;
                idx   <= idx + 1'b1;
                if (live) widx <= widx + 1'b1;
                if (walk_end) count <= live ? widx + 1'b1 : widx;
              end
            end else if (cur.cmd == CMD_INSERT && dup) begin
              dup_hold <= 1'b1;
            end else begin
              if (rd.typ == data_code) dcnt <= dcnt + 1'b1;
              else if (rd.typ == ack_code) acnt <= acnt + 1'b1;
              idx   <= idx + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (res_free) begin
            res.last <= 1'b1;
            if (cur.cmd == CMD_COUNT) begin
              res.kind       <= KIND_COUNTS;
              res.out_handle <= '0;
              res.ttl_left   <= '0;
              res.data_count <= dcnt;
              res.ack_count  <= acnt;
            end else begin
              res.out_handle <= cur.handle;
              res.data_count <= '0;
              res.ack_count  <= '0;
              if (dup_hold) begin
                res.kind     <= KIND_DUP;
                res.ttl_left <= '0;
              end else if (count >= CntW'(NumEntries)) begin
                res.kind     <= KIND_FULL;
                res.ttl_left <= '0;
              end else begin
                res.kind     <= KIND_STORED;
                res.ttl_left <= cur.ttl_in;
              end
            end
          end
        end
        S_WRITE: begin
          count <= count + 1'b1;
        end
        default: ;
      endcase
    end
  end

  `ASSERT_NEVER(a_count_max, clk, rst, count > CntW'(NumEntries))
  `ASSERT_IMPL(a_write_grows, clk, rst, (state == S_WRITE) |=> count == $past(count) + 1'b1)
  `ASSERT_NEVER(a_take_busy, clk, rst, job_take && state != S_IDLE)
endmodule

// ===== rtl/core/dedup_ttl_packet_store_core.sv =====
//------------------------------------------------------------------------------
// dedup_ttl_packet_store_core
// Packet descriptor store with duplicate drop, TTL sweep and type counts.
//------------------------------------------------------------------------------
// channel | direction | handshake
// in      | input     | in_valid / in_stall
// out     | output    | out_valid / out_stall
// cfg     | input     | cfg_valid / cfg_ready
// A stored insert walks the table, emits its result and writes the entry; a
// duplicate insert ends the walk at its match, and a sweep emits per entry.
// The table walk, one entry per cycle unless a sweep is stalled, sets the rate.
// Reset is synchronous; it clears the entry count and sets the type codes to 0 and 1.
// A stalled output holds a sweep walk or an emit; a two-entry queue buffers input jobs.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module dedup_ttl_packet_store_core #(
  parameter int NUM_ENTRIES = dtps_pkg::DefNumEntries
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  handle,
  input  logic [31:0] source_addr,
  input  logic [31:0] dest_addr,
  input  logic [31:0] seq_number,
  input  logic [7:0]  pkt_type,
  input  logic [15:0] ttl_in,
  input  logic [31:0] now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  out_handle,
  output logic [15:0] ttl_left,
  output logic [5:0]  data_count,
  output logic [5:0]  ack_count,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import dtps_pkg::*;

  job_t in_job;
  job_t job;
  logic job_valid;
  logic job_take;
  res_t res;
  logic [7:0] data_code;
  logic [7:0] ack_code;

  assign in_job = '{cmd_t'(command), handle, source_addr, dest_addr, seq_number,
                    pkt_type, ttl_in, now};

  // Type code registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      data_code <= 8'd0;
      ack_code  <= 8'd1;
    end else if (cfg_valid && cfg_index[7:1] == 7'd0) begin
      if (cfg_index[0] == REG_DATA_CODE) data_code <= cfg_data;
      else if (cfg_index[0] == REG_ACK_CODE) ack_code <= cfg_data;
    end
  end

  dtps_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_job,
    .job_valid, .job_take, .job
  );

  dtps_engine #(.NumEntries(NUM_ENTRIES)) u_engine (
    .clk, .rst, .job_valid, .job_take, .job,
    .data_code, .ack_code,
    .res_valid(out_valid), .res_stall(out_stall), .res
  );

  assign kind       = res.kind;
  assign out_handle = res.out_handle;
  assign ttl_left   = res.ttl_left;
  assign data_count = res.data_count;
  assign ack_count  = res.ack_count;
  assign last       = res.last;
endmodule
